@@ hdl/open_addressing_hash_table_unit_macros.svh @@
// assertion macros used by the hash table checker
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define OAHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/oaht_pkg.sv @@
// shared types and codes of the open addressing hash table
package oaht_pkg;

  localparam int KEY_W    = 31;
  localparam int SLOT_W   = 10;
  localparam int CNT_W    = $clog2(KEY_W);
  localparam int WORD_W   = KEY_W + 2;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // result codes
  localparam logic [1:0] RES_DONE  = 2'd0;
  localparam logic [1:0] RES_FOUND = 2'd1;
  localparam logic [1:0] RES_MISS  = 2'd2;
  localparam logic [1:0] RES_FULL  = 2'd3;

  // slot status codes
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  // probe modes
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_QUAD   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PROBE_MODE = 2'd0;
  localparam logic [1:0] CFG_TABLE_SIZE = 2'd1;
  localparam logic [1:0] CFG_STEP_PRIME = 2'd2;

  // reset values
  localparam logic [10:0] TABLE_SIZE_RST = 11'd1024;
  localparam logic [9:0]  STEP_PRIME_RST = 10'd1021;

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    HASH,
    STEP,
    PROBE,
    FIN
  } state_t;

endpackage

@@ hdl/open_addressing_hash_table_unit.sv @@
// Open addressing hash table of 31-bit keys with linear, quadratic or double
// hash probing. After reset a clearing pass marks all TABLE_DEPTH slots empty,
// one slot per cycle, and no beat is taken until it ends. One operation is in
// flight at a time: an unused op code answers with a miss without a search;
// otherwise a serial remainder unit computes key mod m and key mod r (in double
// hashing a second pass also reduces the step mod m), then the slot memory is
// probed one slot per cycle through its registered read port until the
// operation resolves or m slots are seen. Configuration writes are taken any
// time; an operation keeps the settings that were in place when it was accepted.
module open_addressing_hash_table_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // input beat; tdata: op[1:0], key[32:2]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // result beat; tdata: status[1:0], slot[11:2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int MW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = (MW > 10) ? MW : 10;
  localparam int CW = (DW > 11) ? DW : 11;
  localparam int SW = DW + 1;
  localparam int KW = oaht_pkg::KEY_W;

  oaht_pkg::state_t state, state_next;

  logic [1:0]   probe_mode;
  logic [10:0]  table_size;
  logic [9:0]   step_prime;

  logic [1:0]   op;
  logic [KW-1:0] key;
  logic [DW-1:0] m;
  logic [1:0]    op_mode;
  logic [9:0]    op_prime;
  logic [AW-1:0] h;
  logic [AW-1:0] d;
  logic [DW-1:0] cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [AW-1:0] clr_addr;
  logic [1:0]    res_status;
  logic [oaht_pkg::SLOT_W-1:0] res_slot;
  logic [1:0]    out_status;
  logic [oaht_pkg::SLOT_W-1:0] out_slot;

  // combinational controls
  logic          accept;
  logic          mod_start;
  logic [KW-1:0] mod_dividend;
  logic [DW-1:0] mod_div_b;
  logic          mod_done;
  logic [DW-1:0] rem_a;
  logic [DW-1:0] rem_b;
  logic          we;
  logic [AW-1:0] waddr;
  logic [oaht_pkg::WORD_W-1:0] wdata;
  logic [oaht_pkg::WORD_W-1:0] rdata;
  logic [1:0]    rd_st;
  logic [KW-1:0] rd_key;
  logic [DW-1:0] m_cur;
  logic [CW-1:0] tsz;
  logic [9:0]    r_eff;
  logic [DW-1:0] step_s;
  logic [SW-1:0] hsum;
  logic [SW-1:0] dsum;
  logic [AW-1:0] h_adv;
  logic [AW-1:0] d_adv;
  logic          issue;
  logic          term;
  logic [1:0]    term_status;
  logic          load_home;
  logic          load_step;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == oaht_pkg::IDLE);
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = {4'd0, out_slot, out_status};

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode <= oaht_pkg::MODE_LINEAR;
      table_size <= oaht_pkg::TABLE_SIZE_RST;
      step_prime <= oaht_pkg::STEP_PRIME_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        oaht_pkg::CFG_PROBE_MODE: probe_mode <= cfg_data[1:0];
        oaht_pkg::CFG_TABLE_SIZE: table_size <= cfg_data;
        oaht_pkg::CFG_STEP_PRIME: step_prime <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // active size saturated into [2, TABLE_DEPTH]
  always_comb begin
    tsz = CW'(table_size);
    if (tsz < CW'(2)) begin
      m_cur = DW'(2);
    end else if (tsz > CW'(TABLE_DEPTH)) begin
      m_cur = DW'(TABLE_DEPTH);
    end else begin
      m_cur = tsz[DW-1:0];
    end
  end

  // double hashing step r - key mod r, r taken when the beat was accepted
  assign r_eff  = (step_prime == 10'd0) ? 10'd1 : step_prime;
  assign step_s = DW'(op_prime) - rem_b;

  oaht_mod_unit #(.DW(DW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .div_a    (accept ? m_cur : m),
    .div_b    (mod_div_b),
    .done     (mod_done),
    .rem_a    (rem_a),
    .rem_b    (rem_b)
  );

  oaht_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (h),
    .rdata (rdata)
  );

  assign rd_st  = rdata[1:0];
  assign rd_key = rdata[oaht_pkg::WORD_W-1:2];

  // probe address and quadratic increment advance, both kept below m
  always_comb begin
    hsum = SW'(h) + SW'(d);
    if (hsum >= SW'(m)) begin
      hsum = hsum - SW'(m);
    end
    h_adv = hsum[AW-1:0];
    dsum  = SW'(d) + SW'(2);
    if (dsum >= SW'(m)) begin
      dsum = dsum - SW'(m);
    end
    d_adv = (op_mode == oaht_pkg::MODE_QUAD) ? dsum[AW-1:0] : d;
  end

  assign issue = (cnt != m);

  // next state, memory access and remainder unit starts
  always_comb begin
    state_next   = state;
    mod_start    = 1'b0;
    mod_dividend = s_tdata[32:2];
    mod_div_b    = DW'(r_eff);
    we           = 1'b0;
    waddr        = pend_addr;
    wdata        = {key, oaht_pkg::SLOT_USED};
    term         = 1'b0;
    term_status  = oaht_pkg::RES_MISS;
    load_home    = 1'b0;
    load_step    = 1'b0;
    unique case (state)
      oaht_pkg::CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = {KW'(0), oaht_pkg::SLOT_EMPTY};
        if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
          state_next = oaht_pkg::IDLE;
        end
      end
      oaht_pkg::IDLE: begin
        if (accept) begin
          if (s_tdata[1:0] == oaht_pkg::OP_INSERT || s_tdata[1:0] == oaht_pkg::OP_SEARCH ||
              s_tdata[1:0] == oaht_pkg::OP_DELETE) begin
            mod_start  = 1'b1;
            state_next = oaht_pkg::HASH;
          end else begin
            state_next = oaht_pkg::FIN;
          end
        end
      end
      oaht_pkg::HASH: begin
        if (mod_done) begin
          load_home = 1'b1;
          if (op_mode == oaht_pkg::MODE_DOUBLE) begin
            mod_start    = 1'b1;
            mod_dividend = KW'(step_s);
            mod_div_b    = DW'(1);
            state_next   = oaht_pkg::STEP;
          end else begin
            state_next = oaht_pkg::PROBE;
          end
        end
      end
      oaht_pkg::STEP: begin
        if (mod_done) begin
          load_step  = 1'b1;
          state_next = oaht_pkg::PROBE;
        end
      end
      oaht_pkg::PROBE: begin
        if (pend) begin
          if (op == oaht_pkg::OP_INSERT) begin
            if (rd_st != oaht_pkg::SLOT_USED) begin
              term        = 1'b1;
              term_status = oaht_pkg::RES_DONE;
              we          = 1'b1;
            end
          end else if (rd_st == oaht_pkg::SLOT_EMPTY) begin
            term        = 1'b1;
            term_status = oaht_pkg::RES_MISS;
          end else if (rd_st == oaht_pkg::SLOT_USED && rd_key == key) begin
            term = 1'b1;
            if (op == oaht_pkg::OP_DELETE) begin
              term_status = oaht_pkg::RES_DONE;
              we          = 1'b1;
              wdata       = {rd_key, oaht_pkg::SLOT_TOMB};
            end else begin
              term_status = oaht_pkg::RES_FOUND;
            end
          end
        end else if (!issue) begin
          term        = 1'b1;
          term_status = (op == oaht_pkg::OP_INSERT) ? oaht_pkg::RES_FULL : oaht_pkg::RES_MISS;
        end
        if (term) begin
          state_next = oaht_pkg::FIN;
        end
      end
      oaht_pkg::FIN: begin
        if (!m_tvalid || m_tready) begin
          state_next = oaht_pkg::IDLE;
        end
      end
      default: state_next = oaht_pkg::IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= oaht_pkg::CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == oaht_pkg::CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load_home || load_step) begin
        pend <= 1'b0;
        cnt  <= '0;
      end else if (state == oaht_pkg::PROBE) begin
        if (term) begin
          pend <= 1'b0;
        end else begin
          pend <= issue;
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
        end
      end
      if (state == oaht_pkg::FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= s_tdata[1:0];
      key        <= s_tdata[32:2];
      m          <= m_cur;
      op_mode    <= probe_mode;
      op_prime   <= r_eff;
      res_status <= oaht_pkg::RES_MISS;
      res_slot   <= '0;
    end
    if (load_home) begin
      h <= rem_a[AW-1:0];
      d <= AW'(1);
    end
    if (load_step) begin
      d <= rem_a[AW-1:0];
    end
    if (state == oaht_pkg::PROBE && !term && issue) begin
      pend_addr <= h;
      h         <= h_adv;
      d         <= d_adv;
    end
    if (term) begin
      res_status <= term_status;
      res_slot   <= (term_status == oaht_pkg::RES_DONE || term_status == oaht_pkg::RES_FOUND) ?
                    oaht_pkg::SLOT_W'(pend_addr) : '0;
    end
    if (state == oaht_pkg::FIN && (!m_tvalid || m_tready)) begin
      out_status <= res_status;
      out_slot   <= res_slot;
    end
  end

endmodule

@@ hdl/oaht_mod_unit.sv @@
// bit-serial remainder unit, two divisors per pass over a 31-bit dividend
module oaht_mod_unit #(
  parameter int DW = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [oaht_pkg::KEY_W-1:0]   dividend,
  input  logic [DW-1:0]                div_a,
  input  logic [DW-1:0]                div_b,
  output logic                         done,
  output logic [DW-1:0]                rem_a,
  output logic [DW-1:0]                rem_b
);

  logic                         busy;
  logic [oaht_pkg::CNT_W-1:0]   cnt;
  logic [oaht_pkg::KEY_W-1:0]   shreg;
  logic [DW-1:0]                dva;
  logic [DW-1:0]                dvb;

  // one restoring step: shift in a bit, subtract when it fits
  function automatic logic [DW-1:0] rstep(input logic [DW-1:0] r, input logic b,
                                          input logic [DW-1:0] dv);
    logic [DW:0] trial;
    trial = {r, b};
    if (trial >= {1'b0, dv}) begin
      trial = trial - {1'b0, dv};
    end
    return trial[DW-1:0];
  endfunction

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == oaht_pkg::CNT_W'(oaht_pkg::KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem_a <= '0;
      rem_b <= '0;
      dva   <= div_a;
      dvb   <= div_b;
    end else if (busy) begin
      shreg <= {shreg[oaht_pkg::KEY_W-2:0], 1'b0};
      rem_a <= rstep(rem_a, shreg[oaht_pkg::KEY_W-1], dva);
      rem_b <= rstep(rem_b, shreg[oaht_pkg::KEY_W-1], dvb);
    end
  end

endmodule

@@ hdl/oaht_mem.sv @@
// slot memory: key and status per slot, one write and one registered read port
module oaht_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [oaht_pkg::WORD_W-1:0]   wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [oaht_pkg::WORD_W-1:0]   rdata
);

  logic [oaht_pkg::WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/oaht_checker.sv @@
// port-level checks of the hash table, bound to the top level
`include "open_addressing_hash_table_unit_macros.svh"

module oaht_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic [1:0] res_code;
  logic [9:0] res_slot;
  logic       out_stall;
  logic       in_beat;
  logic       no_slot;

  // result fields and handshake shorthands
  assign res_code  = m_tdata[1:0];
  assign res_slot  = m_tdata[11:2];
  assign out_stall = m_tvalid && !m_tready;
  assign in_beat   = s_tvalid && s_tready;
  assign no_slot   = m_tvalid &&
                     (res_code == oaht_pkg::RES_MISS || res_code == oaht_pkg::RES_FULL);

  // a stalled result beat holds
  `OAHT_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled beat changed")

  // miss and full results carry slot zero
  `OAHT_ASSERT_NOW(a_slot_zero, no_slot, res_slot == 10'd0, "slot nonzero on miss or full")

  // clearing pass blocks input right after reset
  `OAHT_ASSERT_NOW(a_clear_block, $past(rst), !s_tready, "input taken during clearing pass")

  // one operation in flight at a time
  `OAHT_ASSERT_NEXT(a_one_item, in_beat, !s_tready, "second item taken while busy")

  // pad bits of the result beat stay zero
  `OAHT_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:12] == 4'd0, "result pad bits set")

endmodule

bind open_addressing_hash_table_unit oaht_checker u_oaht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ dv/tb_top.sv @@
// self-checking testbench of the open addressing hash table unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int STALL_LIMIT = 40000;

  // codes outside the defined sets
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] slot;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;

  // predictor state
  logic [30:0] tbl_key [DEPTH];
  logic [1:0] tbl_state [DEPTH];
  logic [1:0] mode_q;
  logic [10:0] size_q;
  logic [9:0] prime_q;
  result_t pending_results[$];

  int errors = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  logic [30:0] used_keys[$];

  always #4 clk = ~clk;

  open_addressing_hash_table_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // slot of probe number i for a key
  function automatic int probe_index(logic [30:0] key, int i, int m);
    longint off;
    longint r;
    if (mode_q == oaht_pkg::MODE_QUAD) begin
      off = longint'(i) * i;
    end else if (mode_q == oaht_pkg::MODE_DOUBLE) begin
      r = (prime_q == 0) ? 1 : longint'(prime_q);
      off = longint'(i) * (r - key % r);
    end else begin
      off = i;
    end
    return int'((key % m + off % m) % m);
  endfunction

  // apply one operation to the shadow table and give its outcome
  function automatic result_t table_op(logic [1:0] op, logic [30:0] key);
    result_t res;
    int m;
    int h;
    m = (size_q < 2) ? 2 : (size_q > DEPTH) ? DEPTH : int'(size_q);
    res.status = (op == oaht_pkg::OP_INSERT) ? oaht_pkg::RES_FULL : oaht_pkg::RES_MISS;
    res.slot = '0;
    for (int i = 0; i < m; i++) begin
      h = probe_index(key, i, m);
      if (op == oaht_pkg::OP_INSERT) begin
        if (tbl_state[h] != oaht_pkg::SLOT_USED) begin
          tbl_key[h] = key;
          tbl_state[h] = oaht_pkg::SLOT_USED;
          res.status = oaht_pkg::RES_DONE;
          res.slot = h[9:0];
          break;
        end
      end else if (op == oaht_pkg::OP_SEARCH || op == oaht_pkg::OP_DELETE) begin
        if (tbl_state[h] == oaht_pkg::SLOT_EMPTY) break;
        if (tbl_state[h] == oaht_pkg::SLOT_USED && tbl_key[h] == key) begin
          if (op == oaht_pkg::OP_DELETE) begin
            tbl_state[h] = oaht_pkg::SLOT_TOMB;
            res.status = oaht_pkg::RES_DONE;
          end else begin
            res.status = oaht_pkg::RES_FOUND;
          end
          res.slot = h[9:0];
          break;
        end
      end else begin
        break;
      end
    end
    return res;
  endfunction

  // send one operation beat; valid stays up until the next gap or drain
  task automatic send_op(input logic [1:0] op, input logic [30:0] key);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, key, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(table_op(op, key));
    if (op == oaht_pkg::OP_INSERT) used_keys.push_back(key);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == oaht_pkg::CFG_PROBE_MODE) mode_q = val[1:0];
    else if (idx == oaht_pkg::CFG_TABLE_SIZE) size_q = val;
    else if (idx == oaht_pkg::CFG_STEP_PRIME) prime_q = val[9:0];
  endtask

  task automatic set_table(input logic [1:0] mode, input logic [10:0] size,
                           input logic [9:0] prime);
    wait_drained();
    write_reg(oaht_pkg::CFG_PROBE_MODE, {9'd0, mode});
    write_reg(oaht_pkg::CFG_TABLE_SIZE, size);
    write_reg(oaht_pkg::CFG_STEP_PRIME, {1'b0, prime});
    cfg_valid <= 1'b0;
  endtask

  // random key: a reused one half the time if any exist, else small, wide or extreme
  function automatic logic [30:0] pick_key();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5 && used_keys.size() != 0) return used_keys[$urandom_range(used_keys.size() - 1)];
    if (sel == 5) return 31'h7FFFFFFF;
    if (sel < 8) return 31'($urandom_range(63));
    return 31'($urandom);
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", int'(m_tdata[1:0]), -1);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[1:0] != want.status)
            report_mismatch("status", int'(m_tdata[1:0]), int'(want.status));
          if (m_tdata[11:2] != want.slot)
            report_mismatch("slot", int'(m_tdata[11:2]), int'(want.slot));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic test_directed();
    send_op(oaht_pkg::OP_SEARCH, 31'd5);
    send_op(oaht_pkg::OP_DELETE, 31'd5);
    send_op(oaht_pkg::OP_INSERT, 31'd0);
    send_op(oaht_pkg::OP_INSERT, 31'h7FFFFFFF);
    send_op(oaht_pkg::OP_INSERT, 31'd1024);
    send_op(oaht_pkg::OP_INSERT, 31'd1024);
    send_op(oaht_pkg::OP_SEARCH, 31'd1024);
    send_op(oaht_pkg::OP_DELETE, 31'd1024);
    send_op(oaht_pkg::OP_SEARCH, 31'd1024);
    send_op(oaht_pkg::OP_DELETE, 31'd1024);
    send_op(oaht_pkg::OP_DELETE, 31'd1024);
    send_op(OP_UNUSED, 31'h2AAAAAAA);
    send_op(oaht_pkg::OP_SEARCH, 31'h7FFFFFFF);
    send_op(oaht_pkg::OP_SEARCH, 31'h55555555);
  endtask

  // tiny table filled past capacity, degenerate registers
  task automatic test_full_table();
    set_table(oaht_pkg::MODE_LINEAR, 11'd0, 10'd0);
    for (int i = 0; i < 4; i++) send_op(oaht_pkg::OP_INSERT, 31'(i * 7));
    send_op(oaht_pkg::OP_SEARCH, 31'd7);
    set_table(MODE_UNUSED, 11'd2047, 10'd1023);
    send_op(oaht_pkg::OP_INSERT, 31'd3);
    send_op(oaht_pkg::OP_SEARCH, 31'd1);
  endtask

  task automatic test_random_mode(input logic [1:0] mode, input logic [10:0] size,
                                  input logic [9:0] prime, input int n);
    int sel;
    logic [1:0] op;
    set_table(mode, size, prime);
    used_keys.delete();
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(19);
      op = (sel < 8) ? oaht_pkg::OP_INSERT :
           (sel < 14) ? oaht_pkg::OP_SEARCH :
           (sel < 19) ? oaht_pkg::OP_DELETE : OP_UNUSED;
      send_op(op, pick_key());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    mode_q = oaht_pkg::MODE_LINEAR;
    size_q = oaht_pkg::TABLE_SIZE_RST;
    prime_q = oaht_pkg::STEP_PRIME_RST;
    for (int i = 0; i < DEPTH; i++) tbl_state[i] = oaht_pkg::SLOT_EMPTY;
    send_gap_pct = 33;
    recv_gap_pct = 68;
    test_directed();
    test_full_table();
    test_random_mode(oaht_pkg::MODE_LINEAR, 11'd13, 10'd11, 130);
    test_random_mode(oaht_pkg::MODE_QUAD, 11'd16, 10'd13, 130);
    send_gap_pct = 68;
    recv_gap_pct = 33;
    test_random_mode(oaht_pkg::MODE_DOUBLE, 11'd17, 10'd13, 130);
    test_random_mode(oaht_pkg::MODE_DOUBLE, 11'd2, 10'd1, 60);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_mode(oaht_pkg::MODE_QUAD, 11'd64, 10'd61, 150);
    test_random_mode(oaht_pkg::MODE_LINEAR, 11'd1024, 10'd1021, 100);
    test_random_mode(oaht_pkg::MODE_DOUBLE, 11'd1024, 10'd1021, 60);
    wait_drained();
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

@@ open_addressing_hash_table_unit.f @@
+incdir+hdl
hdl/oaht_pkg.sv
hdl/oaht_mod_unit.sv
hdl/oaht_mem.sv
hdl/open_addressing_hash_table_unit.sv
hdl/oaht_checker.sv
dv/tb_top.sv
